// ----- design/vedt_pkg.sv -----
// Package for the 3D vector distance transform block.
// Holds command and status codes, sequencer states and the mask tables.
// No dependencies.
package vedt_pkg;

  localparam int GRID_SIZE = 64;

  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_RUN  = 2'd1,
    CMD_READ = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_LOADED = 2'd0,
    ST_RUN    = 2'd1,
    ST_READ   = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    REG_SIZE_X = 2'd0,
    REG_SIZE_Y = 2'd1,
    REG_SIZE_Z = 2'd2
  } reg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ_WAIT,
    S_READ_DATA,
    S_VOX_START,
    S_CAND_ISSUE,
    S_CAND_WAIT,
    S_CAND_EVAL,
    S_VOX_WRITE,
    S_VOX_NEXT,
    S_OUT
  } state_t;

  typedef enum logic [2:0] {
    MASK_A, MASK_B, MASK_C, MASK_D, MASK_E, MASK_F
  } mask_t;

  localparam int OFF_W  = 7;
  localparam int WORD_W = 22;
  localparam int SQ_W   = 14;
  localparam int CAND_MAX = 14;
  localparam int CIDX_W = 4;

  typedef struct packed {
    logic [1:0] dx;
    logic [1:0] dy;
    logic [1:0] dz;
  } delta_t;

  // Step codes: 0 none, 1 plus one, 3 minus one.
  localparam logic [1:0] DN = 2'd3;
  localparam logic [1:0] D0 = 2'd0;
  localparam logic [1:0] DP = 2'd1;

  function automatic logic [CIDX_W-1:0] mask_count(input mask_t m);
    logic [CIDX_W-1:0] n;
    unique case (m)
      MASK_A, MASK_E: n = 4'd14;
      MASK_C, MASK_F: n = 4'd5;
      default:        n = 4'd2;
    endcase
    return n;
  endfunction

  function automatic delta_t mask_delta(input mask_t m, input logic [CIDX_W-1:0] i);
    delta_t d;
    d = '{D0, D0, D0};
    unique case (m)
      MASK_A, MASK_E: begin
        if (i < 4'd9) begin
          d.dx = (m == MASK_A) ? DN : DP;
          unique case (i)
            4'd0: begin d.dy = DN; d.dz = DN; end
            4'd1: begin d.dy = DN; d.dz = D0; end
            4'd2: begin d.dy = DN; d.dz = DP; end
            4'd3: begin d.dy = D0; d.dz = DN; end
            4'd4: begin d.dy = D0; d.dz = D0; end
            4'd5: begin d.dy = D0; d.dz = DP; end
            4'd6: begin d.dy = DP; d.dz = DN; end
            4'd7: begin d.dy = DP; d.dz = D0; end
            default: begin d.dy = DP; d.dz = DP; end
          endcase
        end else if (m == MASK_A) begin
          unique case (i)
            4'd9:  begin d.dy = DN; d.dz = DN; end
            4'd10: begin d.dy = DN; d.dz = D0; end
            4'd11: begin d.dy = DN; d.dz = DP; end
            4'd12: begin d.dy = D0; d.dz = D0; end
            default: begin d.dy = D0; d.dz = DN; end
          endcase
        end else begin
          unique case (i)
            4'd9:  begin d.dy = D0; d.dz = DP; end
            4'd10: begin d.dy = DP; d.dz = DP; end
            4'd11: begin d.dy = DP; d.dz = D0; end
            4'd12: begin d.dy = D0; d.dz = D0; end
            default: begin d.dy = DP; d.dz = DN; end
          endcase
        end
      end
      MASK_B: d.dz = (i == 4'd0) ? DP : D0;
      MASK_D: d.dz = (i == 4'd0) ? DN : D0;
      MASK_C: begin
        unique case (i)
          4'd0: begin d.dy = D0; d.dz = DP; end
          4'd1: begin d.dy = DP; d.dz = DP; end
          4'd2: begin d.dy = DP; d.dz = D0; end
          4'd3: begin d.dy = D0; d.dz = D0; end
          default: begin d.dy = DP; d.dz = DN; end
        endcase
      end
      default: begin
        unique case (i)
          4'd0: begin d.dy = DN; d.dz = DN; end
          4'd1: begin d.dy = DN; d.dz = D0; end
          4'd2: begin d.dy = DN; d.dz = DP; end
          4'd3: begin d.dy = D0; d.dz = D0; end
          default: begin d.dy = D0; d.dz = DN; end
        endcase
      end
    endcase
    return d;
  endfunction

  function automatic logic [OFF_W-1:0] bump(input logic [OFF_W-1:0] v, input logic [1:0] d);
    return (d != D0 && v != 7'd127) ? v + 7'd1 : v;
  endfunction

endpackage

// ----- design/vector_euclidean_distance_transform_3d_top.sv -----
// Top level of the 3D vector-propagation Euclidean distance transform.
// Holds the voxel memory, the size registers and the pass sequencer.
// Depends on vedt_pkg.
// A load goes from idle to S_OUT; a read passes S_READ_WAIT and S_READ_DATA first.
// A run visits every in-use voxel once per pass (8 passes): S_VOX_START; per mask
// candidate S_CAND_ISSUE, S_CAND_WAIT (inside the grid only), S_CAND_EVAL; then
// S_VOX_WRITE, S_VOX_NEXT. One word is in work at a time; in_stall is high until
// its result is taken. Reset clears control state and the size registers (to
// GRID_SIZE); the voxel memory is not cleared and must be loaded before use.
module vector_euclidean_distance_transform_3d_top import vedt_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       command,
  input  logic [5:0]       pos_x,
  input  logic [5:0]       pos_y,
  input  logic [5:0]       pos_z,
  input  logic             is_seed,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [6:0]       off_x,
  output logic [6:0]       off_y,
  output logic [6:0]       off_z,
  output logic [13:0]      dist_sq,
  output logic             unreached,
  output logic [1:0]       status,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [6:0]       cfg_data
);

  localparam int CW     = $clog2(GRID_SIZE);
  localparam int CW1    = CW + 1;
  localparam int AW     = 3 * CW;
  localparam int DEPTH  = GRID_SIZE * GRID_SIZE * GRID_SIZE;

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rd_data;
  logic [AW-1:0]     rd_addr;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [WORD_W-1:0] wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  logic [6:0] size_x, size_y, size_z;
  logic [CW1-1:0] dim_x, dim_y, dim_z;

  function automatic logic [CW1-1:0] clamp_size(input logic [6:0] r);
    logic [CW1-1:0] v;
    if (r == 7'd0) v = CW1'(1);
    else if (32'(r) > GRID_SIZE) v = CW1'(GRID_SIZE);
    else v = CW1'(r);
    return v;
  endfunction

  assign dim_x = clamp_size(size_x);
  assign dim_y = clamp_size(size_y);
  assign dim_z = clamp_size(size_z);

  state_t state, state_next;

  assign cfg_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      size_x <= 7'd64;
      size_y <= 7'd64;
      size_z <= 7'd64;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SIZE_X: size_x <= cfg_data;
        REG_SIZE_Y: size_y <= cfg_data;
        REG_SIZE_Z: size_z <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pass sequencing: half (x dir), ypart (y dir within half), zpart.
  logic           half, ypart, zpart;
  logic [CW-1:0]  cx, cy, cz;
  logic [CIDX_W-1:0] ci;
  logic           found;
  logic [OFF_W-1:0] bx, by, bz;
  logic [SQ_W+1:0]  best;
  logic           inside_r;
  logic           cand_ok;
  delta_t         cd;

  logic [6:0] r_ox, r_oy, r_oz;
  logic [13:0] r_sq;
  logic        r_unr;
  logic [1:0]  r_status;

  mask_t mask;
  always_comb begin
    unique case ({half, ypart, zpart})
      3'b000: mask = MASK_A;
      3'b001: mask = MASK_B;
      3'b010: mask = MASK_C;
      3'b011: mask = MASK_D;
      3'b100: mask = MASK_E;
      3'b101: mask = MASK_D;
      3'b110: mask = MASK_F;
      default: mask = MASK_B;
    endcase
  end

  // Directions: z ascends for masks A, D, F; y ascends in ypart 0 of the
  // forward half and ypart 1 of the backward half; x ascends in the forward half.
  logic z_up, y_up;
  assign z_up = (mask == MASK_A) || (mask == MASK_D) || (mask == MASK_F);
  assign y_up = (half == ypart);

  logic [CW1-1:0] nx, ny, nz;
  always_comb begin
    cd = (state == S_READ_DATA) ? delta_t'('0) : mask_delta(mask, ci);
    nx = {1'b0, cx} + {{(CW1-2){cd.dx[1]}}, cd.dx};
    ny = {1'b0, cy} + {{(CW1-2){cd.dy[1]}}, cd.dy};
    nz = {1'b0, cz} + {{(CW1-2){cd.dz[1]}}, cd.dz};
    cand_ok = (nx < dim_x) && (ny < dim_y) && (nz < dim_z);
  end

  logic [OFF_W-1:0] ox, oy, oz;
  logic [SQ_W+1:0]  sq;
  assign ox = bump(rd_data[6:0], cd.dx);
  assign oy = bump(rd_data[13:7], cd.dy);
  assign oz = bump(rd_data[20:14], cd.dz);
  assign sq = (SQ_W+2)'(ox) * (SQ_W+2)'(ox) + (SQ_W+2)'(oy) * (SQ_W+2)'(oy)
            + (SQ_W+2)'(oz) * (SQ_W+2)'(oz);

  logic [CW-1:0] z_top, y_top;
  assign z_top = CW'(dim_z - CW1'(1));
  assign y_top = CW'(dim_y - CW1'(1));

  logic z_last, y_last, x_last;
  assign z_last = z_up ? ({1'b0, cz} == dim_z - CW1'(1)) : (cz == '0);
  assign y_last = y_up ? ({1'b0, cy} == dim_y - CW1'(1)) : (cy == '0);
  assign x_last = half ? (cx == '0) : ({1'b0, cx} == dim_x - CW1'(1));

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          unique case (command)
            CMD_LOAD: state_next = S_OUT;
            CMD_RUN:  state_next = S_VOX_START;
            CMD_READ: state_next = S_READ_WAIT;
            default:  state_next = S_IDLE;
          endcase
        end
      end
      S_READ_WAIT:  state_next = S_READ_DATA;
      S_READ_DATA:  state_next = S_OUT;
      S_VOX_START:  state_next = S_CAND_ISSUE;
      S_CAND_ISSUE: state_next = cand_ok ? S_CAND_WAIT : S_CAND_EVAL;
      S_CAND_WAIT:  state_next = S_CAND_EVAL;
      S_CAND_EVAL:  state_next = (ci == mask_count(mask) - 4'd1) ? S_VOX_WRITE : S_CAND_ISSUE;
      S_VOX_WRITE:  state_next = S_VOX_NEXT;
      S_VOX_NEXT:   state_next = (z_last && zpart && y_last && ypart && x_last && half)
                                 ? S_OUT : S_VOX_START;
      S_OUT:        state_next = out_stall ? S_OUT : S_IDLE;
      default:      state_next = S_IDLE;
    endcase
  end

  // Candidate validity captured at issue for use at evaluation.
  logic cand_live;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        ci <= '0;
        half <= 1'b0; ypart <= 1'b0; zpart <= 1'b0;
        cx <= '0; cy <= '0; cz <= '0;
        r_ox <= '0; r_oy <= '0; r_oz <= '0; r_sq <= '0; r_unr <= 1'b0;
        r_status <= (command == CMD_LOAD) ? ST_LOADED
                  : (command == CMD_RUN) ? ST_RUN : ST_READ;
      end
      S_READ_DATA: begin
        if (rd_data[21] && inside_r) begin
          r_ox <= rd_data[6:0];
          r_oy <= rd_data[13:7];
          r_oz <= rd_data[20:14];
          r_sq <= (sq > (SQ_W+2)'(16383)) ? 14'h3fff : sq[SQ_W-1:0];
        end else begin
          r_unr <= 1'b1;
        end
      end
      S_VOX_START: begin
        ci <= '0;
        found <= 1'b0;
        best <= '0;
      end
      S_CAND_ISSUE: cand_live <= cand_ok;
      S_CAND_EVAL: begin
        if (cand_live && rd_data[21] && (!found || sq < best)) begin
          found <= 1'b1;
          best <= sq;
          bx <= ox; by <= oy; bz <= oz;
        end
        ci <= ci + 4'd1;
      end
      S_VOX_NEXT: begin
        if (!z_last) begin
          cz <= z_up ? cz + CW'(1) : cz - CW'(1);
        end else if (!zpart) begin
          zpart <= 1'b1;
        end else begin
          zpart <= 1'b0;
          if (!y_last) begin
            cy <= y_up ? cy + CW'(1) : cy - CW'(1);
            cz <= y_up ? '0 : z_top;
          end else if (!ypart) begin
            ypart <= 1'b1;
            cy <= half ? '0 : y_top;
            cz <= half ? '0 : z_top;
          end else begin
            ypart <= 1'b0;
            if (!x_last) begin
              cx <= half ? cx - CW'(1) : cx + CW'(1);
              cy <= half ? y_top : '0;
              cz <= half ? z_top : '0;
            end else begin
              half <= 1'b1;
              cy <= y_top;
              cz <= z_top;
            end
          end
        end
      end
      default: ;
    endcase
  end

  // Memory port control.
  logic [CW-1:0] px, py, pz;
  assign px = pos_x[CW-1:0];
  assign py = pos_y[CW-1:0];
  assign pz = pos_z[CW-1:0];

  logic pos_in;
  assign pos_in = (32'(pos_x) < GRID_SIZE) && (32'(pos_y) < GRID_SIZE)
               && (32'(pos_z) < GRID_SIZE);

  logic [AW-1:0] rd_pos;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = {cz, cy, cx};
    wr_data = {1'b1, bz, by, bx};
    rd_addr = {nz[CW-1:0], ny[CW-1:0], nx[CW-1:0]};
    if (state == S_IDLE) begin
      rd_addr = {pz, py, px};
      if (in_valid && command == CMD_LOAD && pos_in) begin
        wr_en   = 1'b1;
        wr_addr = {pz, py, px};
        wr_data = {is_seed, 21'd0};
      end
    end else if (state == S_READ_WAIT) begin
      rd_addr = rd_pos;
    end else if (state == S_VOX_WRITE) begin
      wr_en = found;
    end
  end

  // Read path: address presented in idle, data valid in S_READ_DATA.
  always_ff @(posedge clk) begin
    if (state == S_IDLE) begin
      inside_r <= pos_in;
      rd_pos   <= {pz, py, px};
    end
  end

  // The z position does not wrap when a z sub-pass turns around:
  // the last voxel of one sub-pass is the first of the next, so cz holds.

  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_OUT);
  assign off_x     = r_ox;
  assign off_y     = r_oy;
  assign off_z     = r_oz;
  assign dist_sq   = r_sq;
  assign unreached = r_unr;
  assign status    = r_status;

  assert property (@(posedge clk) disable iff (rst) out_valid |-> in_stall)
    else $error("result shown while input taken");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_VOX_WRITE) |-> (ci == mask_count(mask)))
    else $error("voxel written before all candidates were seen");
  assert property (@(posedge clk) disable iff (rst)
    wr_en && (state != S_IDLE) |-> wr_data[21])
    else $error("run wrote an unreached word");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid && $stable(status))
    else $error("stalled result lost");

endmodule
